[hdl/sst_pkg.sv]
// ----------------------------------------------------------------------------
// sst_pkg
// shared types and constants for the set span tracker
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int DIST_W      = $clog2(MAX_ENTRIES + 1);
  localparam int CNT_W       = 11;
  localparam int VAL_W       = 32;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(1024);
  localparam logic [CNT_W-1:0] CAP_LIMIT = CNT_W'(MAX_ENTRIES);

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [CNT_W-1:0]        repeat_count;
  } in_t;

  typedef struct packed {
    logic             status;
    logic             pair_ready;
    logic [VAL_W-1:0] longest_span;
    logic [VAL_W-1:0] shortest_span;
    logic [CNT_W-1:0] stored_count;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_en;
    logic commit;
    logic report;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic skip;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

[hdl/sst_ram.sv]
// ----------------------------------------------------------------------------
// sst_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module sst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/sst_ctrl.sv]
// ----------------------------------------------------------------------------
// sst_ctrl
// sequencer for accept, store scan, state update and result transfer
// ----------------------------------------------------------------------------
module sst_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  sst_pkg::sts_t sts,
  output sst_pkg::cmd_t cmd,
  output logic          in_ready
);
  import sst_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (sts.in_valid) begin
          state_next = sts.skip ? ST_REPORT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        state_next = ST_REPORT;
      end
      ST_REPORT: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = !rst;
        cmd.load = sts.in_valid && !rst;
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
      end
      ST_REPORT: begin
        cmd.report = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[hdl/sst_datapath.sv]
// ----------------------------------------------------------------------------
// sst_datapath
// value store, running bounds, gap scan and result register
// ----------------------------------------------------------------------------
module sst_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  sst_pkg::cmd_t             cmd,
  output sst_pkg::sts_t             sts,
  input  logic                      in_valid,
  input  sst_pkg::in_t              in_data,
  input  logic                      cfg_valid,
  input  logic [sst_pkg::CNT_W-1:0] cfg_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output sst_pkg::out_t             out_data
);
  import sst_pkg::*;

  logic [CNT_W-1:0]        capacity;
  logic [CNT_W-1:0]        cap_eff;
  logic signed [VAL_W-1:0] item_value;
  logic [CNT_W-1:0]        item_reps;
  logic                    item_refused;
  logic                    refuse;

  logic [CNT_W-1:0]        total_count;
  logic [DIST_W-1:0]       distinct;
  logic signed [VAL_W-1:0] run_min;
  logic signed [VAL_W-1:0] run_max;
  logic [VAL_W-1:0]        gap;

  logic [DIST_W-1:0]       idx;
  logic                    rd_pend;
  logic                    present;
  logic [VAL_W-1:0]        gap_work;
  logic                    rd_en;
  logic [VAL_W-1:0]        rdata;
  logic signed [VAL_W-1:0] stored;
  logic [VAL_W-1:0]        diff;
  logic                    wr_en;

  assign cap_eff = (capacity > CAP_LIMIT) ? CAP_LIMIT : capacity;
  assign refuse  = ({1'b0, in_data.repeat_count} + {1'b0, total_count}) > {1'b0, cap_eff};

  assign sts.in_valid  = in_valid;
  assign sts.skip      = refuse || (in_data.repeat_count == '0);
  assign sts.scan_done = (idx == distinct) && !rd_pend;
  assign sts.out_free  = !out_valid || out_ready;

  assign rd_en  = cmd.scan_en && (idx < distinct);
  assign stored = rdata;
  assign diff   = (stored < item_value) ? VAL_W'(item_value - stored)
                                        : VAL_W'(stored - item_value);
  assign wr_en  = cmd.commit && !present && (distinct < DIST_W'(MAX_ENTRIES));

  sst_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (distinct[ADDR_W-1:0]),
    .wdata (item_value),
    .re    (rd_en),
    .raddr (idx[ADDR_W-1:0]),
    .rdata (rdata)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid) begin
      capacity <= cfg_data;
    end
  end

  // item capture and gap scan
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_value   <= in_data.value;
      item_reps    <= in_data.repeat_count;
      item_refused <= refuse;
    end
    if (cmd.load) begin
      present  <= 1'b0;
      gap_work <= gap;
    end else if (cmd.scan_en && rd_pend) begin
      if (diff == '0) begin
        present <= 1'b1;
      end
      if (diff < gap_work) begin
        gap_work <= diff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx     <= '0;
      rd_pend <= 1'b0;
    end else if (cmd.load) begin
      idx     <= '0;
      rd_pend <= 1'b0;
    end else if (cmd.scan_en) begin
      rd_pend <= rd_en;
      if (rd_en) begin
        idx <= idx + 1'b1;
      end
    end
  end

  // set state
  always_ff @(posedge clk) begin
    if (rst) begin
      total_count <= '0;
      distinct    <= '0;
      run_min     <= '0;
      run_max     <= '0;
      gap         <= '1;
    end else if (cmd.commit) begin
      total_count <= total_count + item_reps;
      if (wr_en) begin
        distinct <= distinct + 1'b1;
      end
      if (total_count == '0) begin
        run_min <= item_value;
        run_max <= item_value;
      end else begin
        if (item_value < run_min) begin
          run_min <= item_value;
        end
        if (item_value > run_max) begin
          run_max <= item_value;
        end
      end
      gap <= (item_reps >= CNT_W'(2)) ? '0 : gap_work;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.report) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      out_data.status        <= item_refused;
      out_data.pair_ready    <= total_count >= CNT_W'(2);
      out_data.longest_span  <= (total_count >= CNT_W'(2)) ? VAL_W'(run_max - run_min) : '0;
      out_data.shortest_span <= (total_count >= CNT_W'(2)) ? gap : '0;
      out_data.stored_count  <= total_count;
    end
  end

endmodule

[hdl/set_span_tracker.sv]
// an add goes from input transfer through the store scan, commit and report states to the result,
// the scan reading one stored word per distinct value held; a refused or zero-count item skips
// scan and commit and goes straight to report; one item is in work at a time
// throughput is set by the store scan, one store read per cycle
// reset clears counts and bounds, sets gap to all ones and capacity to 1024; store words are not cleared
// ----------------------------------------------------------------------------
// set_span_tracker
// bounded multiset of signed numbers reporting longest and shortest span
// ----------------------------------------------------------------------------
module set_span_tracker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  sst_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output sst_pkg::out_t             out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [sst_pkg::CNT_W-1:0] cfg_data
);
  import sst_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = !rst;

  sst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  sst_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_pair_flag : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.pair_ready == (out_data.stored_count >= CNT_W'(2))))
    else $error("pair_ready disagrees with stored_count");

  a_spans_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.pair_ready) |->
      (out_data.longest_span == '0 && out_data.shortest_span == '0))
    else $error("spans not zero without a pair");

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.stored_count <= CAP_LIMIT))
    else $error("stored_count above store depth");

  a_one_item : assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while one is in work");

endmodule
